// File: rtl/stq_pkg.sv
`default_nettype none
package stq_pkg;
    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;
endpackage
`default_nettype wire

// File: rtl/sorted_timer_queue.sv
`default_nettype none
// Channel  | Direction | Signals                                       | Handshake
// command  | in        | opcode, timer_id, delay_ticks, keep_if_pending | start && !busy
// result   | out       | status, fired_valid, fired_timer, last_result | result_strobe
//
// Arm walks the sorted list one entry a cycle: a search pass finds the slot and a
// shift-in pass moves the tail up and writes the timer in, and re-arming a pending
// timer first runs an unlink scan and a shift-out pass. Cancel runs the unlink scan
// and the shift-out pass. A tick spends one head check plus a shift pass over the
// remaining list per fired timer and one final check, up to sixteen fired timers.
// The shared unit is one time comparator and one list shifter. Reset clears time,
// pending flags and length.
// The receiver cannot stall: each result word is shown for one cycle.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int TIMER_COUNT = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  timer_id,
    input  wire logic [19:0] delay_ticks,
    input  wire logic        keep_if_pending,
    output logic             result_strobe,
    output logic             status,
    output logic             fired_valid,
    output logic [3:0]       fired_timer,
    output logic             last_result
);
    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int LW = $clog2(TIMER_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_SHIFT_OUT, S_SEARCH, S_SHIFT_IN, S_TICK_HEAD
    } state_t;

    state_t                 state_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic [TIME_WIDTH-1:0]  deadline_reg [TIMER_COUNT];
    logic [IW-1:0]          order_reg [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] pending_reg;
    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          pos_reg;
    logic [IW-1:0]          id_reg;
    logic                   arm_reg;
    logic [4:0]             fired_count_reg;
    logic                   fired_any_reg;
    logic [IW-1:0]          cmd_id;

    assign cmd_id = IW'(timer_id);

    // Wrap-aware "a later than b", shared by search and expiry.
    logic [TIME_WIDTH-1:0] cmp_a, cmp_b, cmp_d;
    logic                  cmp_later;
    always_comb
    begin
        cmp_a = deadline_reg[order_reg[pos_reg[IW-1:0]]];
        cmp_b = (state_reg == S_SEARCH) ? deadline_reg[id_reg] : time_reg;
        if (state_reg == S_TICK_HEAD)
        begin
            cmp_a = deadline_reg[order_reg[0]];
        end
        cmp_d     = cmp_a - cmp_b;
        cmp_later = (cmp_d != '0) && !cmp_d[TIME_WIDTH-1];
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            time_reg        <= '0;
            pending_reg     <= '0;
            len_reg         <= '0;
            result_strobe   <= 1'b0;
            pos_reg         <= '0;
            id_reg          <= '0;
            arm_reg         <= 1'b0;
            fired_count_reg <= '0;
            fired_any_reg   <= 1'b0;
            status          <= 1'b0;
            fired_valid     <= 1'b0;
            fired_timer     <= '0;
            last_result     <= 1'b0;
        end
        else
        begin
            result_strobe <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        status      <= 1'b1;
                        fired_valid <= 1'b0;
                        fired_timer <= '0;
                        last_result <= 1'b1;
                        id_reg      <= cmd_id;
                        pos_reg     <= '0;
                        if (opcode == OP_TICK)
                        begin
                            time_reg        <= time_reg + 1'b1;
                            fired_count_reg <= '0;
                            fired_any_reg   <= 1'b0;
                            state_reg       <= S_TICK_HEAD;
                        end
                        else if (opcode == OP_NONE || 32'(timer_id) >= TIMER_COUNT)
                        begin
                            result_strobe <= 1'b1;
                        end
                        else if (opcode == OP_ARM)
                        begin
                            if (pending_reg[cmd_id] && keep_if_pending)
                            begin
                                result_strobe <= 1'b1;
                            end
                            else
                            begin
                                arm_reg <= 1'b1;
                                deadline_reg[cmd_id] <= time_reg
                                    + TIME_WIDTH'(delay_ticks);
                                state_reg <= pending_reg[cmd_id] ?
                                             S_FIND : S_SEARCH;
                            end
                        end
                        else
                        begin
                            if (!pending_reg[cmd_id])
                            begin
                                result_strobe <= 1'b1;
                            end
                            else
                            begin
                                arm_reg   <= 1'b0;
                                state_reg <= S_FIND;
                            end
                        end
                    end
                end
                S_FIND:
                begin
                    // Locate the timer in the list.
                    if (pos_reg >= len_reg)
                    begin
                        pending_reg[id_reg] <= 1'b0;
                        pos_reg   <= '0;
                        state_reg <= arm_reg ? S_SEARCH : S_IDLE;
                        if (!arm_reg)
                        begin
                            status <= 1'b0;
                            result_strobe <= 1'b1;
                        end
                    end
                    else if (order_reg[pos_reg[IW-1:0]] == id_reg)
                    begin
                        state_reg <= S_SHIFT_OUT;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_SHIFT_OUT:
                begin
                    // Close the gap one entry a cycle.
                    if (pos_reg + 1'b1 < len_reg)
                    begin
                        order_reg[pos_reg[IW-1:0]] <= order_reg[pos_reg[IW-1:0] + 1'b1];
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg - 1'b1;
                        pending_reg[id_reg] <= 1'b0;
                        pos_reg <= '0;
                        if (fired_count_reg != '0 && !arm_reg && state_reg == S_SHIFT_OUT
                            && fired_any_reg)
                        begin
                            // The previous fired word has been strobed by now, so
                            // the word for this timer can take its place.
                            fired_valid <= 1'b1;
                            fired_timer <= 4'(id_reg);
                            last_result <= 1'b0;
                            state_reg   <= S_TICK_HEAD;
                        end
                        else if (arm_reg)
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            status        <= 1'b0;
                            result_strobe <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (pos_reg < len_reg && !cmp_later)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        // Reuse fired_count_reg as target; shift from the tail.
                        fired_count_reg <= 5'(pos_reg);
                        pos_reg   <= len_reg;
                        state_reg <= S_SHIFT_IN;
                    end
                end
                S_SHIFT_IN:
                begin
                    if (pos_reg > LW'(fired_count_reg))
                    begin
                        order_reg[pos_reg[IW-1:0]] <= order_reg[pos_reg[IW-1:0] - 1'b1];
                        pos_reg <= pos_reg - 1'b1;
                    end
                    else
                    begin
                        order_reg[pos_reg[IW-1:0]] <= id_reg;
                        len_reg             <= len_reg + 1'b1;
                        pending_reg[id_reg] <= 1'b1;
                        fired_count_reg     <= '0;
                        arm_reg             <= 1'b0;
                        status              <= 1'b0;
                        result_strobe       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                S_TICK_HEAD:
                begin
                    status <= 1'b0;
                    if (len_reg != '0 && !cmp_later && fired_count_reg < 5'd16)
                    begin
                        id_reg          <= order_reg[0];
                        fired_count_reg <= fired_count_reg + 1'b1;
                        fired_any_reg   <= 1'b1;
                        arm_reg         <= 1'b0;
                        // Strobe the previous fired word, still held on the
                        // outputs, now that another one follows.
                        result_strobe   <= fired_any_reg;
                        pos_reg         <= '0;
                        state_reg       <= S_SHIFT_OUT;
                    end
                    else
                    begin
                        if (!fired_any_reg)
                        begin
                            fired_valid <= 1'b0;
                            fired_timer <= '0;
                        end
                        last_result     <= 1'b1;
                        result_strobe   <= 1'b1;
                        fired_count_reg <= '0;
                        fired_any_reg   <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: test/timer_queue_checker.sv
`timescale 1ns / 100ps
module timer_queue_checker
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  timer_id,
    input  wire logic [19:0] delay_ticks,
    input  wire logic        keep_if_pending,
    input  wire logic        result_strobe,
    input  wire logic        status,
    input  wire logic        fired_valid,
    input  wire logic [3:0]  fired_timer,
    input  wire logic        last_result,
    output int               failures,
    output int               words_waiting,
    output int               fired_seen
);
    typedef struct packed {
        logic       status;
        logic       fired_valid;
        logic [3:0] fired_timer;
        logic       last_result;
    } result_word_t;

    localparam int TIMERS = 16;

    // Shadow of the timer list.
    logic [31:0] now_ms;
    logic [31:0] due_at [TIMERS];
    logic        armed [TIMERS];
    logic [3:0]  order [TIMERS];
    int          depth;

    result_word_t expected_words [$];

    function automatic logic later_than(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 0) && !d[31];
    endfunction

    task automatic remove_timer(input logic [3:0] id);
        int i;
        for (i = 0; i < depth; i++) begin
            if (order[i] == id) begin
                for (int j = i; j + 1 < depth; j++) order[j] = order[j + 1];
                depth--;
                break;
            end
        end
        armed[id] = 1'b0;
    endtask

    task automatic insert_timer(input logic [3:0] id);
        int pos;
        pos = 0;
        if (depth >= TIMERS) return;
        while (pos < depth && !later_than(due_at[order[pos]], due_at[id])) pos++;
        for (int j = depth; j > pos; j--) order[j] = order[j - 1];
        order[pos] = id;
        depth++;
        armed[id] = 1'b1;
    endtask

    task automatic push_word(input logic s, input logic fv, input logic [3:0] ft,
                             input logic last);
        result_word_t w;
        w.status = s;
        w.fired_valid = fv;
        w.fired_timer = ft;
        w.last_result = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_command(input opcode_t op, input logic [3:0] id,
                                   input logic [19:0] dly, input logic keep);
        int fired;
        logic [3:0] head;
        fired = 0;
        case (op)
            OP_TICK:
            begin
                now_ms = now_ms + 1;
                while (fired < TIMERS && depth > 0) begin
                    head = order[0];
                    if (later_than(due_at[head], now_ms)) break;
                    remove_timer(head);
                    push_word(1'b0, 1'b1, head, 1'b0);
                    fired++;
                end
                if (fired == 0) push_word(1'b0, 1'b0, 4'd0, 1'b1);
                else expected_words[$].last_result = 1'b1;
            end
            OP_ARM:
            begin
                if (armed[id] && keep) begin
                    push_word(1'b1, 1'b0, 4'd0, 1'b1);
                end
                else begin
                    if (armed[id]) remove_timer(id);
                    due_at[id] = now_ms + 32'(dly);
                    insert_timer(id);
                    push_word(1'b0, 1'b0, 4'd0, 1'b1);
                end
            end
            OP_CANCEL:
            begin
                if (!armed[id]) begin
                    push_word(1'b1, 1'b0, 4'd0, 1'b1);
                end
                else begin
                    remove_timer(id);
                    push_word(1'b0, 1'b0, 4'd0, 1'b1);
                end
            end
            default: push_word(1'b1, 1'b0, 4'd0, 1'b1);
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        failures++;
    endtask

    initial
    begin
        failures = 0;
        fired_seen = 0;
        words_waiting = 0;
        now_ms = '0;
        depth = 0;
        for (int i = 0; i < TIMERS; i++) armed[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n) begin
            if (start && !busy)
                predict_command(opcode_t'(opcode), timer_id, delay_ticks, keep_if_pending);
            if (result_strobe) begin
                if (fired_valid) fired_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end
                else begin
                    want = expected_words.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  status, want.status));
                    if (fired_valid !== want.fired_valid)
                        report_mismatch($sformatf("fired_valid %b, expected %b",
                                                  fired_valid, want.fired_valid));
                    if (fired_timer !== want.fired_timer)
                        report_mismatch($sformatf("fired_timer %0d, expected %0d",
                                                  fired_timer, want.fired_timer));
                    if (last_result !== want.last_result)
                        report_mismatch($sformatf("last_result %b, expected %b",
                                                  last_result, want.last_result));
                end
            end
            words_waiting = expected_words.size();
        end
    end
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import stq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [19:0] delay_ticks;
    logic        keep_if_pending;
    logic        result_strobe;
    logic        status;
    logic        fired_valid;
    logic [3:0]  fired_timer;
    logic        last_result;
    int          failures;
    int          words_waiting;
    int          fired_seen;
    int          commands_sent;

    sorted_timer_queue dut (.*);

    // The checker sits beside the block and sees the same pins.
    timer_queue_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one command word and hold it until the block takes it. Inputs only
    // change on the falling edge, so the checker samples settled values. With no
    // gap, start stays high and the next word follows straight away.
    task automatic send_command(input opcode_t op, input logic [3:0] id,
                                input logic [19:0] dly, input logic keep);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        timer_id <= id;
        delay_ticks <= dly;
        keep_if_pending <= keep;
        @(posedge clk);
        while (busy) @(posedge clk);
        commands_sent++;
        @(negedge clk);
    endtask

    task automatic tick_times(input int count);
        for (int i = 0; i < count; i++) send_command(OP_TICK, 4'd0, 20'd0, 1'b0);
    endtask

    // Hold back until every predicted word has come out of the block.
    task automatic drain_results();
        start <= 1'b0;
        while (words_waiting != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    initial
    begin
        int pick;
        logic [19:0] dly;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_NONE;
        timer_id = '0;
        delay_ticks = '0;
        keep_if_pending = 1'b0;
        commands_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: errors on an empty list, zero delay, extreme delays, equal
        // deadlines keeping arm order, re-arm, refused re-arm, ignored opcode.
        send_command(OP_CANCEL, 4'd3, 20'd0, 1'b0);
        send_command(OP_NONE, 4'hF, 20'hFFFFF, 1'b1);
        tick_times(1);
        send_command(OP_ARM, 4'd0, 20'd0, 1'b0);
        send_command(OP_ARM, 4'd15, 20'hFFFFF, 1'b0);
        send_command(OP_ARM, 4'd5, 20'd2, 1'b0);
        send_command(OP_ARM, 4'd9, 20'd2, 1'b0);
        send_command(OP_ARM, 4'd7, 20'd2, 1'b0);
        send_command(OP_ARM, 4'd5, 20'd2, 1'b1);
        send_command(OP_ARM, 4'd9, 20'd2, 1'b0);
        send_command(OP_ARM, 4'd10, 20'h80000, 1'b0);
        send_command(OP_CANCEL, 4'd15, 20'd0, 1'b0);
        send_command(OP_CANCEL, 4'd15, 20'd0, 1'b1);
        tick_times(3);
        // All sixteen timers due together: the largest burst of fired words.
        for (int i = 0; i < 16; i++) send_command(OP_ARM, 4'(15 - i), 20'd1, 1'b0);
        tick_times(2);
        drain_results();

        // Random part: mostly arms with short delays and ticks so that timers
        // do expire, plus cancels, refused re-arms and the odd long delay.
        for (int n = 0; n < 195; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0) dly = 20'($urandom);
            else dly = 20'($urandom_range(0, 6));
            if (pick < 40)
                send_command(OP_ARM, 4'($urandom), dly, 1'($urandom));
            else if (pick < 55)
                send_command(OP_CANCEL, 4'($urandom), 20'($urandom), 1'($urandom));
            else if (pick < 97)
                send_command(OP_TICK, 4'($urandom), 20'($urandom), 1'($urandom));
            else
                send_command(OP_NONE, 4'($urandom), 20'($urandom), 1'($urandom));
            if (n == 100) drain_results();
        end

        drain_results();
        $display("Sent %0d command words; %0d timers fired in deadline order.",
                 commands_sent, fired_seen);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Timeout for the whole run: about 230 commands plus the gaps between them.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
